// File: design/dlgs_pkg.sv
// ----------------------------------------------------------------------------
// dlgs_pkg: shared types and constants
// Gun masks, sequencer states and the modulo unit result bundle.
// ----------------------------------------------------------------------------
package dlgs_pkg;

  localparam int unsigned GUN_COUNT  = 6;
  localparam int unsigned DIST_W     = 32;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned CYC_W      = LEN_W + 1;
  localparam int unsigned DIV_W      = CYC_W + 1;
  localparam int unsigned WIDTH_W    = 8;
  localparam int unsigned CNT_W      = $clog2(DIST_W);

  localparam logic [GUN_COUNT-1:0] MaskAll    = 6'h3F;
  localparam logic [GUN_COUNT-1:0] MaskMiddle = 6'h0E;
  localparam logic [GUN_COUNT-1:0] MaskLeft   = 6'h07;
  localparam logic [GUN_COUNT-1:0] MaskRight  = 6'h38;
  localparam logic [GUN_COUNT-1:0] MaskOff    = 6'h00;

  localparam logic [WIDTH_W-1:0] WidthNarrow = 8'd12;
  localparam logic [WIDTH_W-1:0] WidthWide   = 8'd24;

  // configuration register indexes
  localparam logic [1:0] RegLineLen   = 2'd0;
  localparam logic [1:0] RegGapLen    = 2'd1;
  localparam logic [1:0] RegLineWidth = 2'd2;
  localparam logic [1:0] RegReversible = 2'd3;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StBusy = 3'b010,
    StDone = 3'b100
  } seq_state_e;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] rem;
  } mod_res_t;

endpackage

// File: design/dlgs_modulo.sv
// ----------------------------------------------------------------------------
// dlgs_modulo: iterative remainder unit
// Restoring division, one dividend bit per cycle; returns the remainder only.
// ----------------------------------------------------------------------------
module dlgs_modulo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [dlgs_pkg::DIST_W-1:0]   dividend_i,
  input  logic [dlgs_pkg::DIV_W-1:0]    divisor_i,
  output dlgs_pkg::mod_res_t            res_o
);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [dlgs_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [dlgs_pkg::DIST_W-1:0]  shf_q, shf_d;
  logic [dlgs_pkg::DIV_W-1:0]   rem_q, rem_d;
  logic [dlgs_pkg::DIV_W-1:0]   div_q, div_d;
  logic [dlgs_pkg::DIV_W:0]     trial;
  logic [dlgs_pkg::DIV_W:0]     diff;

  assign trial = {rem_q, shf_q[dlgs_pkg::DIST_W-1]};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    shf_d  = shf_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      shf_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      shf_d = {shf_q[dlgs_pkg::DIST_W-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem_d = diff[dlgs_pkg::DIV_W-1:0];
      end else begin
        rem_d = trial[dlgs_pkg::DIV_W-1:0];
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == dlgs_pkg::CNT_W'(dlgs_pkg::DIST_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shf_q <= shf_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign res_o.done = done_q;
  assign res_o.rem  = rem_q;

endmodule

// File: design/dashed_line_gun_sequencer.sv
// ----------------------------------------------------------------------------
// dashed_line_gun_sequencer: paint-gun relay sequencer for dashed lines
// Per distance word, drives six gun relays from dash/gap position and width.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  in      | in_valid_i/in_ready_o, distance/painting/rev | word in
//  out     | out_valid_o/out_ready_i, gun_mask_o         | word out
//  cfg     | cfg_we_i, cfg_idx_i, cfg_data_i             | write only
//
// A dashed word is accepted, then runs 32 steps of the remainder unit
// (distance mod twice the cycle); the remainder is taken, then the result
// is loaded into the output register.
// Not painting or continuous line: the remainder unit is skipped.
// A waiting result lets the next word in; that word then holds in its result
// cycle, with the input not ready, until the waiting result is taken.
// Reset: relays off, no output, width 12, idle, line/gap/reversible zero.
module dashed_line_gun_sequencer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [dlgs_pkg::DIST_W-1:0]         distance_cm_i,
  input  logic                                painting_i,
  input  logic                                reversed_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [dlgs_pkg::GUN_COUNT-1:0]      gun_mask_o,
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_idx_i,
  input  logic [dlgs_pkg::LEN_W-1:0]          cfg_data_i
);

  dlgs_pkg::seq_state_e                state_q, state_d;
  logic [dlgs_pkg::LEN_W-1:0]          line_q, gap_q;
  logic [dlgs_pkg::WIDTH_W-1:0]        width_q;
  logic                                rev_q;
  logic                                painting_q, reversed_q, skip_q;
  logic [dlgs_pkg::DIV_W-1:0]          rem_q;
  logic                                out_valid_q, out_valid_d;
  logic [dlgs_pkg::GUN_COUNT-1:0]      mask_q, mask_d;

  logic                                accept;
  logic                                start;
  logic [dlgs_pkg::CYC_W-1:0]          cycle;
  logic [dlgs_pkg::DIV_W-1:0]          cycle_ext;
  logic                                half2;
  logic [dlgs_pkg::DIV_W-1:0]          pos;
  logic                                dash;
  logic [dlgs_pkg::GUN_COUNT-1:0]      wmask;
  logic [dlgs_pkg::GUN_COUNT-1:0]      new_mask;
  logic                                load_out;
  dlgs_pkg::mod_res_t                  mod_res;

  assign in_ready_o = (state_q == dlgs_pkg::StIdle);
  assign accept     = in_valid_i & in_ready_o;
  assign start      = accept & painting_i & (line_q != '0);
  assign cycle      = {1'b0, line_q} + {1'b0, gap_q};
  assign cycle_ext  = {1'b0, cycle};

  dlgs_modulo u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .dividend_i (distance_cm_i),
    .divisor_i  ({cycle, 1'b0}),
    .res_o      (mod_res)
  );

  // result from remainder of twice the cycle
  assign half2 = (rem_q >= cycle_ext);
  assign pos   = half2 ? (rem_q - cycle_ext) : rem_q;
  assign dash  = (pos < {2'b00, line_q});

  always_comb begin
    if (width_q == dlgs_pkg::WidthNarrow) begin
      wmask = dlgs_pkg::MaskMiddle;
    end else if (width_q == dlgs_pkg::WidthWide) begin
      wmask = dlgs_pkg::MaskAll;
    end else begin
      wmask = mask_q;
    end
  end

  always_comb begin
    if (!painting_q) begin
      new_mask = dlgs_pkg::MaskOff;
    end else if (skip_q) begin
      new_mask = wmask;
    end else if (rev_q && !half2) begin
      if (reversed_q) begin
        new_mask = dlgs_pkg::MaskRight | (dash ? dlgs_pkg::MaskLeft : dlgs_pkg::MaskOff);
      end else begin
        new_mask = dlgs_pkg::MaskLeft | (dash ? dlgs_pkg::MaskRight : dlgs_pkg::MaskOff);
      end
    end else begin
      new_mask = dash ? wmask : dlgs_pkg::MaskOff;
    end
  end

  assign load_out = (state_q == dlgs_pkg::StDone) & (~out_valid_q | out_ready_i);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    mask_d      = mask_q;
    unique case (state_q)
      dlgs_pkg::StIdle: begin
        if (accept) begin
          state_d = start ? dlgs_pkg::StBusy : dlgs_pkg::StDone;
        end
      end
      dlgs_pkg::StBusy: begin
        if (mod_res.done) begin
          state_d = dlgs_pkg::StDone;
        end
      end
      dlgs_pkg::StDone: begin
        if (load_out) begin
          state_d     = dlgs_pkg::StIdle;
          out_valid_d = 1'b1;
          mask_d      = new_mask;
        end
      end
      default: state_d = dlgs_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dlgs_pkg::StIdle;
      out_valid_q <= 1'b0;
      mask_q      <= dlgs_pkg::MaskOff;
      line_q      <= '0;
      gap_q       <= '0;
      width_q     <= dlgs_pkg::WidthNarrow;
      rev_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      mask_q      <= mask_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          dlgs_pkg::RegLineLen:    line_q  <= cfg_data_i;
          dlgs_pkg::RegGapLen:     gap_q   <= cfg_data_i;
          dlgs_pkg::RegLineWidth:  width_q <= cfg_data_i[dlgs_pkg::WIDTH_W-1:0];
          dlgs_pkg::RegReversible: rev_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      painting_q <= painting_i;
      reversed_q <= reversed_i;
      skip_q     <= ~start;
    end
    if (mod_res.done) begin
      rem_q <= mod_res.rem;
    end
  end

  assign out_valid_o = out_valid_q;
  assign gun_mask_o  = mask_q;

endmodule

// File: design/dlgs_checker.sv
// ----------------------------------------------------------------------------
// dlgs_checker: port-level checks for the gun sequencer
// Handshake hold, single-word occupancy and legal relay patterns.
// ----------------------------------------------------------------------------
module dlgs_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic [dlgs_pkg::GUN_COUNT-1:0]      gun_mask_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(gun_mask_o))
    else $error("result word dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready after accepting a word");

  a_mask_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (gun_mask_o == dlgs_pkg::MaskOff) ||
                    (gun_mask_o == dlgs_pkg::MaskMiddle) ||
                    (gun_mask_o == dlgs_pkg::MaskAll) ||
                    (gun_mask_o == dlgs_pkg::MaskLeft) ||
                    (gun_mask_o == dlgs_pkg::MaskRight))
    else $error("illegal relay pattern");

endmodule

bind dashed_line_gun_sequencer dlgs_checker u_dlgs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .gun_mask_o  (gun_mask_o)
);
